// File: hw/rtl/jpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the joint PD effort controller.
package jpd_pkg;

    localparam int GAIN_W     = 10;
    localparam int GAIN_SLOTS = 6;
    localparam int TABLE_W    = GAIN_W * GAIN_SLOTS;
    localparam int GATE_W     = 9;
    localparam int TICKS_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TABLE_W;
    localparam int ACC_W      = 36;
    localparam int MUL_W      = 18;
    localparam int DIVD_W     = 32;
    localparam int DIVS_W     = TICKS_W + 1;
    localparam int QUO_W      = 16;

    localparam logic [TABLE_W-1:0] KP_RESET    = 60'd901600394609460000;
    localparam logic [TABLE_W-1:0] KD_RESET    = 60'd54096023676567600;
    localparam logic [GATE_W-1:0]  GATE_RESET  = 9'd205;
    localparam logic [GATE_W-1:0]  GATE_ONE    = 9'd256;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd1000;

    localparam logic signed [ACC_W-1:0] LP_HALF  = 36'sd128;
    localparam logic signed [ACC_W-1:0] PD_HALF  = 36'sd8;
    localparam logic signed [ACC_W-1:0] PD_MAX_A = 36'sd12288;
    localparam logic signed [ACC_W-1:0] PD_MIN_A = -36'sd12288;
    localparam logic signed [14:0]      PD_MAX   = 15'sd12288;
    localparam logic signed [14:0]      PD_MIN   = -15'sd12288;
    localparam logic signed [16:0]      SUM_MAX_W = 17'sd20480;
    localparam logic signed [16:0]      SUM_MIN_W = -17'sd20480;
    localparam logic signed [15:0]      SUM_MAX  = 16'sd20480;
    localparam logic signed [15:0]      SUM_MIN  = -16'sd20480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_TABLE      = 3'd0,
        CFG_KD_TABLE      = 3'd1,
        CFG_VELOCITY_GATE = 3'd2,
        CFG_TORQUE_GATE   = 3'd3,
        CFG_RAMP_TICKS    = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MAC_NONE,
        MAC_VEL_OLD,
        MAC_VEL_RAW,
        MAC_TRQ_OLD,
        MAC_TRQ_RAW,
        MAC_KP,
        MAC_KD,
        MAC_RAMP
    } mac_sel_t;

    typedef struct packed {
        logic [2:0]         joint;
        logic signed [15:0] meas_pos;
        logic signed [15:0] meas_vel;
        logic signed [15:0] meas_torque;
        logic signed [15:0] target_pos;
        logic signed [15:0] target_vel;
        logic signed [15:0] target_torque;
        logic               new_period;
        logic               restart;
    } sample_t;

    typedef struct packed {
        logic [2:0]         out_joint;
        logic signed [15:0] effort_cmd;
        logic signed [15:0] state_pos;
        logic signed [15:0] state_vel;
        logic signed [15:0] state_torque;
    } result_t;

    typedef struct packed {
        logic     capture;
        mac_sel_t mac_sel;
        logic     acc_add;
        logic     lat_fv;
        logic     lat_ft;
        logic     lat_pd;
        logic     lat_sum;
        logic     div_start;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic full_scale;
        logic div_done;
        logic out_free;
    } status_t;

    // Gain of one joint from a packed table; slots past the table read as zero.
    function automatic logic [GAIN_W-1:0] gain_of(input logic [TABLE_W-1:0] tbl,
                                                  input logic [2:0] j);
        logic [GAIN_W-1:0] g;
        g = '0;
        for (int s = 0; s < GAIN_SLOTS; s++) begin
            if (j == 3'(s))
            begin
                g = tbl[s*GAIN_W +: GAIN_W];
            end
        end
        return g;
    endfunction

endpackage

// File: hw/rtl/jpd_if.sv
`timescale 1ns / 1ps
// Sample and command stream interfaces of the joint PD effort controller.
interface jpd_sample_if;
    logic               valid;
    logic               ready;
    logic [2:0]         joint;
    logic signed [15:0] meas_pos;
    logic signed [15:0] meas_vel;
    logic signed [15:0] meas_torque;
    logic signed [15:0] target_pos;
    logic signed [15:0] target_vel;
    logic signed [15:0] target_torque;
    logic               new_period;
    logic               restart;

    modport source (
        output valid, joint, meas_pos, meas_vel, meas_torque, target_pos,
               target_vel, target_torque, new_period, restart,
        input  ready
    );
    modport sink (
        input  valid, joint, meas_pos, meas_vel, meas_torque, target_pos,
               target_vel, target_torque, new_period, restart,
        output ready
    );
endinterface

interface jpd_command_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_joint;
    logic signed [15:0] effort_cmd;
    logic signed [15:0] state_pos;
    logic signed [15:0] state_vel;
    logic signed [15:0] state_torque;

    modport source (
        output valid, out_joint, effort_cmd, state_pos, state_vel, state_torque,
        input  ready
    );
    modport sink (
        input  valid, out_joint, effort_cmd, state_pos, state_vel, state_torque,
        output ready
    );
endinterface

// File: hw/rtl/jpd_div.sv
`timescale 1ns / 1ps
// Restoring divider, two quotient bits per cycle, 16-bit quotient.
module jpd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [jpd_pkg::DIVD_W-1:0]  dividend,
    input  logic [jpd_pkg::DIVS_W-1:0]  divisor,
    output logic                        done,
    output logic [jpd_pkg::QUO_W-1:0]   quotient
);
    import jpd_pkg::*;

    localparam int STEPS = QUO_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    // caller guarantees dividend[31:16] < divisor, so the quotient fits 16 bits
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dsr_reg;
    logic [QUO_W-1:0]  num_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   t1, t2;
    logic [DIVS_W-1:0] r1;
    logic              q1, q2;

    always_comb
    begin
        t1 = {rem_reg, num_reg[QUO_W-1]};
        q1 = (t1 >= {1'b0, dsr_reg});
        r1 = q1 ? DIVS_W'(t1 - {1'b0, dsr_reg}) : t1[DIVS_W-1:0];
        t2 = {r1, num_reg[QUO_W-2]};
        q2 = (t2 >= {1'b0, dsr_reg});
        rem_next = q2 ? DIVS_W'(t2 - {1'b0, dsr_reg}) : t2[DIVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend[DIVD_W-1:QUO_W]};
            num_reg <= dividend[QUO_W-1:0];
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= {num_reg[QUO_W-3:0], 2'b00};
            quo_reg <= {quo_reg[QUO_W-3:0], q1, q2};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/jpd_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, filter stores, shared MAC, clamps, ramp scaling.
module jpd_datapath #(
    parameter int NUM_JOINTS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  jpd_pkg::cmd_t                  cmd,
    output jpd_pkg::status_t               status,
    input  jpd_pkg::sample_t               sample,
    input  logic                           cfg_we,
    input  logic [jpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jpd_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output jpd_pkg::result_t               result
);
    import jpd_pkg::*;

    localparam int IDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    // configuration
    logic [TABLE_W-1:0] kp_reg, kd_reg;
    logic [GATE_W-1:0]  vgate_reg, tgate_reg;
    logic [TICKS_W-1:0] ticks_reg;

    // per-item state
    sample_t            sample_reg;
    logic [TICKS_W-1:0] ramp_reg, ramp_next;
    logic signed [15:0] vel_store_reg [NUM_JOINTS];
    logic signed [15:0] trq_store_reg [NUM_JOINTS];
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [15:0] fv_reg, ft_reg;
    logic signed [14:0] pd_reg, pd_next;
    logic signed [15:0] sum_reg, sum_next;
    logic               out_valid_reg;
    result_t            result_reg, result_next;

    logic               joint_ok;
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] old_vel, old_trq;
    logic [GATE_W-1:0]  vg, tg;
    logic signed [16:0] perr, verr;
    logic signed [MUL_W-1:0] mac_a, mac_b;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] lp_round, pd_round;
    logic signed [16:0] sum_wide;
    logic [14:0]        mag;
    logic               full_scale;
    logic               div_done;
    logic [QUO_W-1:0]   quo;
    logic [DIVD_W-1:0]  dividend;
    logic signed [15:0] ramped;

    assign joint_ok = (32'(sample_reg.joint) < NUM_JOINTS);
    assign idx      = IDX_W'(sample_reg.joint);
    assign old_vel  = joint_ok ? vel_store_reg[idx] : '0;
    assign old_trq  = joint_ok ? trq_store_reg[idx] : '0;

    // gate above one saturates to one
    assign vg = (vgate_reg > GATE_ONE) ? GATE_ONE : vgate_reg;
    assign tg = (tgate_reg > GATE_ONE) ? GATE_ONE : tgate_reg;

    assign perr = {sample_reg.target_pos[15], sample_reg.target_pos}
                - {sample_reg.meas_pos[15], sample_reg.meas_pos};
    assign verr = {sample_reg.target_vel[15], sample_reg.target_vel}
                - {fv_reg[15], fv_reg};

    assign mag = sum_reg[15] ? 15'(-sum_reg) : sum_reg[14:0];

    // shared multiplier operand select
    always_comb
    begin
        unique case (cmd.mac_sel)
            MAC_NONE:
            begin
                mac_a = '0;
                mac_b = '0;
            end
            MAC_VEL_OLD:
            begin
                mac_a = {9'd0, vg};
                mac_b = {{2{old_vel[15]}}, old_vel};
            end
            MAC_VEL_RAW:
            begin
                mac_a = {9'd0, 9'(GATE_ONE - vg)};
                mac_b = {{2{sample_reg.meas_vel[15]}}, sample_reg.meas_vel};
            end
            MAC_TRQ_OLD:
            begin
                mac_a = {9'd0, tg};
                mac_b = {{2{old_trq[15]}}, old_trq};
            end
            MAC_TRQ_RAW:
            begin
                mac_a = {9'd0, 9'(GATE_ONE - tg)};
                mac_b = {{2{sample_reg.meas_torque[15]}}, sample_reg.meas_torque};
            end
            MAC_KP:
            begin
                mac_a = {8'd0, gain_of(kp_reg, sample_reg.joint)};
                mac_b = {perr[16], perr};
            end
            MAC_KD:
            begin
                mac_a = {8'd0, gain_of(kd_reg, sample_reg.joint)};
                mac_b = {verr[16], verr};
            end
            MAC_RAMP:
            begin
                mac_a = {3'd0, mag};
                mac_b = {2'd0, ramp_reg};
            end
        endcase
    end

    assign prod     = mac_a * mac_b;
    assign acc_next = cmd.acc_add ? acc_reg + prod : prod;

    // round half up, then clamp the PD term
    assign lp_round = (acc_reg + LP_HALF) >>> 8;
    assign pd_round = (acc_reg + PD_HALF) >>> 4;

    always_comb
    begin
        if (pd_round > PD_MAX_A)
        begin
            pd_next = PD_MAX;
        end
        else if (pd_round < PD_MIN_A)
        begin
            pd_next = PD_MIN;
        end
        else
        begin
            pd_next = pd_round[14:0];
        end
    end

    assign sum_wide = {{2{pd_reg[14]}}, pd_reg}
                    + {sample_reg.target_torque[15], sample_reg.target_torque};

    always_comb
    begin
        if (sum_wide > SUM_MAX_W)
        begin
            sum_next = SUM_MAX;
        end
        else if (sum_wide < SUM_MIN_W)
        begin
            sum_next = SUM_MIN;
        end
        else
        begin
            sum_next = sum_wide[15:0];
        end
    end

    // ramp count update at capture; restart wins
    always_comb
    begin
        ramp_next = ramp_reg;
        if (sample.restart)
        begin
            ramp_next = '0;
        end
        else if (sample.new_period && (ramp_reg < ticks_reg))
        begin
            ramp_next = ramp_reg + 1'b1;
        end
    end

    assign full_scale = (ticks_reg == '0) || (ramp_reg >= ticks_reg);

    // (2*mag*count + ticks) / (2*ticks), rounding half away from zero
    assign dividend = {acc_reg[DIVD_W-2:0], 1'b0} + {{(DIVD_W-TICKS_W){1'b0}}, ticks_reg};

    jpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  ({ticks_reg, 1'b0}),
        .done     (div_done),
        .quotient (quo)
    );

    assign ramped = full_scale ? sum_reg : (sum_reg[15] ? 16'(-quo) : quo);

    always_comb
    begin
        result_next.out_joint    = sample_reg.joint;
        result_next.state_pos    = sample_reg.meas_pos;
        result_next.effort_cmd   = joint_ok ? ramped : '0;
        result_next.state_vel    = joint_ok ? fv_reg : '0;
        result_next.state_torque = joint_ok ? ft_reg : '0;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg    <= KP_RESET;
            kd_reg    <= KD_RESET;
            vgate_reg <= GATE_RESET;
            tgate_reg <= GATE_RESET;
            ticks_reg <= TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KP_TABLE:      kp_reg    <= cfg_data;
                CFG_KD_TABLE:      kd_reg    <= cfg_data;
                CFG_VELOCITY_GATE: vgate_reg <= cfg_data[GATE_W-1:0];
                CFG_TORQUE_GATE:   tgate_reg <= cfg_data[GATE_W-1:0];
                CFG_RAMP_TICKS:    ticks_reg <= cfg_data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // control-side state: ramp, filter stores, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_JOINTS; i++)
            begin
                vel_store_reg[i] <= '0;
                trq_store_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.capture)
            begin
                ramp_reg <= ramp_next;
            end
            if (cmd.lat_fv && joint_ok)
            begin
                vel_store_reg[idx] <= lp_round[15:0];
            end
            if (cmd.lat_ft && joint_ok)
            begin
                trq_store_reg[idx] <= lp_round[15:0];
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
        if (cmd.mac_sel != MAC_NONE)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.lat_fv)
        begin
            fv_reg <= lp_round[15:0];
        end
        if (cmd.lat_ft)
        begin
            ft_reg <= lp_round[15:0];
        end
        if (cmd.lat_pd)
        begin
            pd_reg <= pd_next;
        end
        if (cmd.lat_sum)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.load_out)
        begin
            result_reg <= result_next;
        end
    end

    assign status.full_scale = full_scale;
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign result            = result_reg;

endmodule

// File: hw/rtl/jpd_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps one sample through the datapath.
module jpd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  jpd_pkg::status_t status,
    output jpd_pkg::cmd_t    cmd
);
    import jpd_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_V0   = 13'b0000000000010,
        ST_V1   = 13'b0000000000100,
        ST_T0   = 13'b0000000001000,
        ST_T1   = 13'b0000000010000,
        ST_P0   = 13'b0000000100000,
        ST_P1   = 13'b0000001000000,
        ST_S0   = 13'b0000010000000,
        ST_S1   = 13'b0000100000000,
        ST_R0   = 13'b0001000000000,
        ST_R1   = 13'b0010000000000,
        ST_DIV  = 13'b0100000000000,
        ST_DONE = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mac_sel = MAC_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_V0;
                end
            end
            ST_V0:
            begin
                cmd.mac_sel = MAC_VEL_OLD;
                state_next  = ST_V1;
            end
            ST_V1:
            begin
                cmd.mac_sel = MAC_VEL_RAW;
                cmd.acc_add = 1'b1;
                state_next  = ST_T0;
            end
            ST_T0:
            begin
                cmd.lat_fv  = 1'b1;
                cmd.mac_sel = MAC_TRQ_OLD;
                state_next  = ST_T1;
            end
            ST_T1:
            begin
                cmd.mac_sel = MAC_TRQ_RAW;
                cmd.acc_add = 1'b1;
                state_next  = ST_P0;
            end
            ST_P0:
            begin
                cmd.lat_ft  = 1'b1;
                cmd.mac_sel = MAC_KP;
                state_next  = ST_P1;
            end
            ST_P1:
            begin
                cmd.mac_sel = MAC_KD;
                cmd.acc_add = 1'b1;
                state_next  = ST_S0;
            end
            ST_S0:
            begin
                cmd.lat_pd = 1'b1;
                state_next = ST_S1;
            end
            ST_S1:
            begin
                cmd.lat_sum = 1'b1;
                state_next  = status.full_scale ? ST_DONE : ST_R0;
            end
            ST_R0:
            begin
                cmd.mac_sel = MAC_RAMP;
                state_next  = ST_R1;
            end
            ST_R1:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/joint_pd_effort_controller.sv
`timescale 1ns / 1ps
// Top level of the joint PD effort controller.
//
// One sample transfer in gives one command transfer out. Per sample the block
// low-pass filters velocity and torque with per-joint state, forms the PD
// effort from the position and filtered velocity errors (clamped to +-12.0),
// adds the target torque (clamped to +-20.0) and scales it by the soft-start
// ramp count / ramp_ticks. Work runs on one shared 18x18 multiply-accumulate
// unit and a 2-bit-per-cycle divider, one sample at a time. When the ramp is
// at full scale the sum goes straight to the output register; while the ramp
// is still rising the sequencer first runs the ramp multiply and the divider.
// The result sits in an output register, so the next sample is accepted as
// soon as the sequencer is back in idle even if the previous command has not
// been taken; a sample only waits at the end of its run if that register is
// still occupied.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while no sample is in flight: the block itself does not enforce it.
// A joint index at or above NUM_JOINTS leaves the filters alone and returns
// zero effort and zero filtered state; the ramp still advances.
module joint_pd_effort_controller #(
    parameter int NUM_JOINTS = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    jpd_sample_if.sink                      samples,
    jpd_command_if.source                   commands,
    input  logic                            cfg_we,
    input  logic [jpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jpd_pkg::*;

    cmd_t    cmd;
    status_t status;
    sample_t sample;
    result_t result;
    logic    out_valid;
    logic    in_ready;

    // pack the incoming transfer
    always_comb
    begin
        sample.joint         = samples.joint;
        sample.meas_pos      = samples.meas_pos;
        sample.meas_vel      = samples.meas_vel;
        sample.meas_torque   = samples.meas_torque;
        sample.target_pos    = samples.target_pos;
        sample.target_vel    = samples.target_vel;
        sample.target_torque = samples.target_torque;
        sample.new_period    = samples.new_period;
        sample.restart       = samples.restart;
    end

    assign samples.ready = in_ready;

    // sequencer
    jpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, state and config
    jpd_datapath #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (commands.ready),
        .result    (result)
    );

    // unpack the outgoing transfer
    assign commands.valid        = out_valid;
    assign commands.out_joint    = result.out_joint;
    assign commands.effort_cmd   = result.effort_cmd;
    assign commands.state_pos    = result.state_pos;
    assign commands.state_vel    = result.state_vel;
    assign commands.state_torque = result.state_torque;

`ifndef SYNTH
    // command never leaves the +-20.0 band
    a_effort_range: assert property (@(posedge clk) disable iff (!rst_n)
        commands.valid |-> (commands.effort_cmd <= 16'sd20480 &&
                            commands.effort_cmd >= -16'sd20480))
        else $error("effort_cmd out of range");

    // unknown joint gives zero command and zero filtered state
    a_bad_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (commands.valid && (32'(commands.out_joint) >= NUM_JOINTS)) |->
            (commands.effort_cmd == '0 && commands.state_vel == '0 &&
             commands.state_torque == '0))
        else $error("out-of-range joint produced nonzero output");

    // one sample in flight: accept drops ready on the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("second sample accepted while busy");
`endif

endmodule
